[design/bb_pkg.sv]
package bb_pkg;

	localparam int CH_W   = 8;
	localparam int CSUM_W = 10;
	localparam int SUM_W  = 12;
	localparam int CNT_W  = 4;
	localparam int RCP_W  = 20;
	localparam int RSH    = 20;
	localparam int X_W    = SUM_W + 1;
	localparam int PROD_W = X_W + RCP_W;
	localparam int FD     = 8;
	localparam int FA     = 3;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef struct packed {
		logic [CSUM_W-1:0] r;
		logic [CSUM_W-1:0] g;
		logic [CSUM_W-1:0] b;
	} csum_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sum_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic top_en;
		logic bot_en;
	} cell_ctl_t;

	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bot;
		logic fe;
	} mask_t;

	typedef struct packed {
		pix_t px;
		logic fe;
	} result_t;

	// ceil(2^RSH / (2*count)) for the neighbor counts that can occur
	function automatic logic [RCP_W-1:0] bb_recip(input logic [CNT_W-1:0] cnt);
		logic [RCP_W-1:0] r;
		case (cnt)
			4'd1:    r = RCP_W'(524288);
			4'd2:    r = RCP_W'(262144);
			4'd3:    r = RCP_W'(174763);
			4'd4:    r = RCP_W'(131072);
			4'd6:    r = RCP_W'(87382);
			4'd9:    r = RCP_W'(58255);
			default: r = RCP_W'(524288);
		endcase
		return r;
	endfunction

endpackage

[design/bb_if.sv]
interface bb_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, kind, red, green, blue, input ready);
	modport sink(input valid, kind, red, green, blue, output ready);
endinterface

interface bb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       frame_end;

	modport source(output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink(input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

[design/box_blur_3x3_edge_clipped.sv]
// 3x3 box blur of an RGB888 raster stream with edge clipping. Each pixel beat yields the
// rounded-half-up per-channel mean of its in-frame 3x3 neighbors; the result for pixel k
// leaves with input beat k+W+1, so W+1 drain beats (kind=1) flush a frame, and drains after
// that are swallowed. A kind=0 beat after the flush starts the next frame. The block takes one
// beat per clock: the window is a chain of three column cells that shift once per beat, and
// the two line stores are single-port-per-side RAMs read at the beat's column and written in
// the next cycle, with a bypass when consecutive beats hit the same column. A result passes
// through the s1, s2, s3 and s4 registers and then an eight-entry output queue; input
// ready drops only while eight results are queued or in flight. Registers: frame_width at
// byte 0 (0 acts as 1, values above MAX_WIDTH saturate), frame_height at byte 4 (0 acts as
// 1); a write restarts the frame and keeps the line stores. Line store contents need no
// clearing after reset.
module box_blur_3x3_edge_clipped import bb_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	bb_in_if.sink       pixel,
	bb_out_if.source    result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int LW = EW + 1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		PH_PIX   = 3'b001,
		PH_FLUSH = 3'b010,
		PH_DONE  = 3'b100
	} phase_t;

	logic [10:0]   width_q;
	logic [11:0]   height_q;
	phase_t        phase_q;
	logic [AW-1:0] in_col_q;
	logic [11:0]   in_row_q;
	logic [EW-1:0] flush_q;
	logic [LW-1:0] lead_q;
	logic [AW-1:0] ocol_q;
	logic [11:0]   orow_q;

	logic          cfg_wr;
	logic [31:0]   wx;
	logic [EW-1:0] eff_w;
	logic [EW-1:0] w_m1;
	logic [LW-1:0] w_p1;
	logic [11:0]   eff_h;
	logic [11:0]   h_m1;

	logic          acc;
	logic          work;
	logic          restart;
	phase_t        c_phase;
	phase_t        n_phase;
	logic [AW-1:0] c_col;
	logic [AW-1:0] n_col;
	logic [11:0]   c_row;
	logic [11:0]   n_row;
	logic [EW-1:0] n_flush;
	logic [LW-1:0] c_lead;
	logic [AW-1:0] c_ocol;
	logic [11:0]   c_orow;
	logic          col_last;
	logic          ocol_last;
	logic          orow_last;
	logic          emit;
	logic          is_pix;
	pix_t          pix_in;
	mask_t         mask_in;

	logic          v_s1;
	logic          e_s1;
	pix_t          pix_s1;
	logic [AW-1:0] cn_s1;
	logic          wr_s1;
	logic          clr_s1;
	mask_t         mask_s1;
	logic          byp_s1;
	pix_t          byp_top_s1;
	pix_t          byp_mid_s1;
	pix_t          ram_top;
	pix_t          ram_mid;
	pix_t          top_eff;
	pix_t          mid_eff;

	logic          e_s2;
	mask_t         mask_s2;
	logic [CNT_W-1:0] cnt_s2;
	logic [1:0]    ncols;
	logic [1:0]    nrows;

	logic          e_s3;
	sum_t          sum_s3;
	logic [CNT_W-1:0] cnt_s3;
	logic [RCP_W-1:0] rcp_s3;
	logic          fe_s3;

	logic          e_s4;
	logic          fe_s4;
	pix_t          mean_s4;

	cell_ctl_t     ctl;
	col_t          col_in  [3];
	col_t          col_out [3];
	csum_t         csum    [3];

	result_t       fifo_q [FD];
	logic [FA-1:0] wp_q;
	logic [FA-1:0] rp_q;
	logic [FA:0]   cnt_q;
	logic [FA:0]   pend;
	logic          push;
	logic          pop;

	// configuration port
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

	always_comb begin
		wx = 32'(width_q);
		if (wx == 32'd0) begin
			eff_w = EW'(1);
		end else if (wx > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(wx);
		end
		eff_h = (height_q == 12'd0) ? 12'd1 : height_q;
		w_m1  = eff_w - EW'(1);
		w_p1  = LW'(eff_w) + LW'(1);
		h_m1  = eff_h - 12'd1;
	end

	// beat intake and frame position
	assign acc     = pixel.valid && pixel.ready;
	assign restart = (phase_q == PH_DONE);
	assign work    = acc && !(restart && pixel.kind);

	always_comb begin
		c_phase   = restart ? PH_PIX : phase_q;
		c_col     = restart ? '0 : in_col_q;
		c_row     = restart ? '0 : in_row_q;
		c_lead    = restart ? '0 : lead_q;
		c_ocol    = restart ? '0 : ocol_q;
		c_orow    = restart ? '0 : orow_q;
		col_last  = (EW'(c_col) == w_m1);
		ocol_last = (EW'(c_ocol) == w_m1);
		orow_last = (c_orow == h_m1);
		emit      = (c_lead == w_p1);
		is_pix    = (c_phase == PH_PIX);
		n_col     = col_last ? '0 : c_col + AW'(1);
		n_row     = c_row;
		n_flush   = flush_q;
		n_phase   = c_phase;
		case (c_phase)
			PH_PIX: begin
				if (col_last) begin
					if (c_row == h_m1) begin
						n_phase = PH_FLUSH;
						n_flush = '0;
					end else begin
						n_row = c_row + 12'd1;
					end
				end
			end
			PH_FLUSH: begin
				if (flush_q == eff_w) begin
					n_phase = PH_DONE;
				end else begin
					n_flush = flush_q + EW'(1);
				end
			end
			PH_DONE: begin
				n_phase = PH_DONE;
			end
			default: begin
				n_phase = PH_PIX;
			end
		endcase
		pix_in.r      = (is_pix && !pixel.kind) ? pixel.red : 8'd0;
		pix_in.g      = (is_pix && !pixel.kind) ? pixel.green : 8'd0;
		pix_in.b      = (is_pix && !pixel.kind) ? pixel.blue : 8'd0;
		mask_in.left  = (c_ocol != '0);
		mask_in.right = !ocol_last;
		mask_in.top   = (c_orow != 12'd0);
		mask_in.bot   = !orow_last;
		mask_in.fe    = ocol_last && orow_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 12'd480;
			phase_q  <= PH_PIX;
			in_col_q <= '0;
			in_row_q <= '0;
			flush_q  <= '0;
			lead_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[11:0];
				default:    width_q <= width_q;
			endcase
			phase_q  <= PH_PIX;
			in_col_q <= '0;
			in_row_q <= '0;
			flush_q  <= '0;
			lead_q   <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
		end else if (work) begin
			phase_q  <= n_phase;
			in_col_q <= n_col;
			in_row_q <= n_row;
			flush_q  <= n_flush;
			lead_q   <= emit ? c_lead : c_lead + LW'(1);
			if (emit) begin
				ocol_q <= ocol_last ? '0 : c_ocol + AW'(1);
				orow_q <= ocol_last ? c_orow + 12'd1 : c_orow;
			end else begin
				ocol_q <= c_ocol;
				orow_q <= c_orow;
			end
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			e_s1 <= 1'b0;
			e_s2 <= 1'b0;
			e_s3 <= 1'b0;
			e_s4 <= 1'b0;
		end else begin
			v_s1 <= work;
			e_s1 <= work && emit;
			e_s2 <= e_s1;
			e_s3 <= e_s2;
			e_s4 <= e_s3;
		end
	end

	// line stores, read at intake, written in the next cycle
	bb_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (AW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (work),
		.rd_addr (c_col),
		.rd_top  (ram_top),
		.rd_mid  (ram_mid),
		.wr_en   (v_s1 && wr_s1),
		.wr_addr (cn_s1),
		.wr_top  (mid_eff),
		.wr_mid  (pix_s1)
	);

	assign top_eff = byp_s1 ? byp_top_s1 : ram_top;
	assign mid_eff = byp_s1 ? byp_mid_s1 : ram_mid;

	always_ff @(posedge clk) begin
		pix_s1     <= pix_in;
		cn_s1      <= c_col;
		wr_s1      <= is_pix;
		clr_s1     <= restart;
		mask_s1    <= mask_in;
		byp_s1     <= v_s1 && wr_s1 && (cn_s1 == c_col);
		byp_top_s1 <= mid_eff;
		byp_mid_s1 <= pix_s1;
	end

	// window: three column cells, newest on the right
	assign ctl.clear  = cfg_wr;
	assign ctl.shift  = v_s1;
	assign ctl.top_en = mask_s2.top;
	assign ctl.bot_en = mask_s2.bot;

	assign col_in[2] = '{top: top_eff, mid: mid_eff, bot: pix_s1};
	assign col_in[1] = clr_s1 ? '0 : col_out[2];
	assign col_in[0] = clr_s1 ? '0 : col_out[1];

	for (genvar i = 0; i < 3; i++) begin : g_cell
		bb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.col_in  (col_in[i]),
			.col_out (col_out[i]),
			.sum     (csum[i])
		);
	end

	assign ncols = 2'd1 + {1'b0, mask_s1.left} + {1'b0, mask_s1.right};
	assign nrows = 2'd1 + {1'b0, mask_s1.top} + {1'b0, mask_s1.bot};

	always_ff @(posedge clk) begin
		mask_s2 <= mask_s1;
		cnt_s2  <= CNT_W'(ncols) * CNT_W'(nrows);
	end

	always_ff @(posedge clk) begin
		sum_s3.r <= SUM_W'(mask_s2.left ? csum[0].r : {CSUM_W{1'b0}}) + SUM_W'(csum[1].r)
			+ SUM_W'(mask_s2.right ? csum[2].r : {CSUM_W{1'b0}});
		sum_s3.g <= SUM_W'(mask_s2.left ? csum[0].g : {CSUM_W{1'b0}}) + SUM_W'(csum[1].g)
			+ SUM_W'(mask_s2.right ? csum[2].g : {CSUM_W{1'b0}});
		sum_s3.b <= SUM_W'(mask_s2.left ? csum[0].b : {CSUM_W{1'b0}}) + SUM_W'(csum[1].b)
			+ SUM_W'(mask_s2.right ? csum[2].b : {CSUM_W{1'b0}});
		cnt_s3   <= cnt_s2;
		rcp_s3   <= bb_recip(cnt_s2);
		fe_s3    <= mask_s2.fe;
		fe_s4    <= fe_s3;
	end

	bb_mean u_mean_r (.clk(clk), .sum(sum_s3.r), .cnt(cnt_s3), .rcp(rcp_s3), .mean(mean_s4.r));
	bb_mean u_mean_g (.clk(clk), .sum(sum_s3.g), .cnt(cnt_s3), .rcp(rcp_s3), .mean(mean_s4.g));
	bb_mean u_mean_b (.clk(clk), .sum(sum_s3.b), .cnt(cnt_s3), .rcp(rcp_s3), .mean(mean_s4.b));

	// output queue
	assign push = e_s4;
	assign pop  = result.valid && result.ready;
	assign pend = cnt_q + (FA+1)'(e_s1) + (FA+1)'(e_s2) + (FA+1)'(e_s3) + (FA+1)'(e_s4);

	assign pixel.ready = (pend < (FA+1)'(FD));

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{px: mean_s4, fe: fe_s4};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FA'(1);
			end
			if (pop) begin
				rp_q <= rp_q + FA'(1);
			end
			cnt_q <= cnt_q + (FA+1)'(push) - (FA+1)'(pop);
		end
	end

	assign result.valid     = (cnt_q != '0);
	assign result.out_red   = fifo_q[rp_q].px.r;
	assign result.out_green = fifo_q[rp_q].px.g;
	assign result.out_blue  = fifo_q[rp_q].px.b;
	assign result.frame_end = fifo_q[rp_q].fe;

endmodule

[design/bb_line_store.sv]
module bb_line_store import bb_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pix_t          rd_top,
	output pix_t          rd_mid,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pix_t          wr_top,
	input  pix_t          wr_mid
);

	pix_t upper_q [DEPTH];
	pix_t lower_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_q[wr_addr] <= wr_top;
			lower_q[wr_addr] <= wr_mid;
		end
		if (rd_en) begin
			rd_top <= upper_q[rd_addr];
			rd_mid <= lower_q[rd_addr];
		end
	end

endmodule

[design/bb_cell.sv]
module bb_cell import bb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  col_t      col_in,
	output col_t      col_out,
	output csum_t     sum
);

	col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.clear) begin
			col_q <= '0;
		end else if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	always_comb begin
		sum.r = CSUM_W'(ctl.top_en ? col_q.top.r : 8'd0) + CSUM_W'(col_q.mid.r)
			+ CSUM_W'(ctl.bot_en ? col_q.bot.r : 8'd0);
		sum.g = CSUM_W'(ctl.top_en ? col_q.top.g : 8'd0) + CSUM_W'(col_q.mid.g)
			+ CSUM_W'(ctl.bot_en ? col_q.bot.g : 8'd0);
		sum.b = CSUM_W'(ctl.top_en ? col_q.top.b : 8'd0) + CSUM_W'(col_q.mid.b)
			+ CSUM_W'(ctl.bot_en ? col_q.bot.b : 8'd0);
	end

endmodule

[design/bb_mean.sv]
module bb_mean import bb_pkg::*; (
	input  logic             clk,
	input  logic [SUM_W-1:0] sum,
	input  logic [CNT_W-1:0] cnt,
	input  logic [RCP_W-1:0] rcp,
	output logic [CH_W-1:0]  mean
);

	logic [X_W-1:0]        x;
	logic [PROD_W-1:0]     prod;
	logic [PROD_W-RSH-1:0] quo_s4;

	assign x    = {sum, 1'b0} + X_W'(cnt);
	assign prod = PROD_W'(x) * PROD_W'(rcp);

	always_ff @(posedge clk) begin
		quo_s4 <= prod[PROD_W-1:RSH];
	end

	assign mean = (quo_s4 > (PROD_W-RSH)'(255)) ? 8'hFF : quo_s4[CH_W-1:0];

endmodule

[bench/box_blur_3x3_edge_clipped_test.sv]
`timescale 1ns / 1ps

module box_blur_3x3_edge_clipped_test import bb_pkg::*; ();

	localparam int LINE_DEPTH    = 64;
	localparam int ITEMS         = 500;
	localparam int SETTLE_CYCLES = 12;
	localparam int END_CYCLES    = 20;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PRINT_CAP     = 50;
	localparam logic REG_WIDTH   = 1'b0;
	localparam logic REG_HEIGHT  = 1'b1;

	typedef enum logic [1:0] {STEP_WRITE, STEP_READ, STEP_BEAT} step_op_t;

	typedef struct packed {
		step_op_t    op;
		logic        idx;
		logic [31:0] value;
		logic        kind;
		pix_t        px;
		logic        known;
		result_t     want;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bb_in_if  pix_if();
	bb_out_if res_if();

	box_blur_3x3_edge_clipped #(
		.MAX_WIDTH (LINE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pix_if),
		.result  (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	int unsigned width_reg = 640;
	int unsigned height_reg = 480;
	pix_t        upper_line [LINE_DEPTH];
	pix_t        lower_line [LINE_DEPTH];
	pix_t        win_col [3][3];
	int unsigned taken_n;
	int unsigned col_at;
	int unsigned row_at;

	result_t     blurred_q [$];
	int unsigned mismatches;
	int unsigned beats_fed;
	int unsigned quiet;
	bit          calm;
	bit          need_rewrite;
	bit          big_done;

	step_t plan [32] = '{
		'{STEP_READ,  REG_WIDTH,  32'd640,  1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_READ,  REG_HEIGHT, 32'd480,  1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_WIDTH,  32'd0,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_HEIGHT, 32'd0,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_READ,  REG_WIDTH,  32'd0,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'hFFFFFF, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b1, {24'hFFFFFF, 1'b1}},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'hFFFFFF, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'hFFFFFF, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b1, {24'h000000, 1'b1}},
		'{STEP_WRITE, REG_WIDTH,  32'd2,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_HEIGHT, 32'd2,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'hFF00FF, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'h00FF00, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'hFFFFFF, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'hFFFFFF, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_WIDTH,  32'd1,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_HEIGHT, 32'd3,    1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'h010203, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'h020304, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b0, 24'hFEFF00, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b0, 25'h0},
		'{STEP_BEAT,  REG_WIDTH,  32'd0,    1'b1, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_WIDTH,  32'd2047, 1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_WRITE, REG_HEIGHT, 32'd4095, 1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_READ,  REG_WIDTH,  32'd2047, 1'b0, 24'h000000, 1'b0, 25'h0},
		'{STEP_READ,  REG_HEIGHT, 32'd4095, 1'b0, 24'h000000, 1'b0, 25'h0}
	};

	task automatic report(input string msg);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int unsigned idle_len();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] random_channel();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic pix_t random_pixel();
		pix_t p;
		p.r = random_channel();
		p.g = random_channel();
		p.b = random_channel();
		return p;
	endfunction

	function automatic int unsigned eff_w();
		if (width_reg == 0)
			return 1;
		return (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
	endfunction

	function automatic int unsigned eff_h();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic void restart_frame();
		foreach (win_col[i, j])
			win_col[i][j] = '0;
		taken_n = 0;
		col_at = 0;
		row_at = 0;
	endfunction

	function automatic logic [7:0] round_mean(input int unsigned s, input int unsigned c);
		int unsigned v;
		v = (2 * s + c) / (2 * c);
		return (v > 255) ? 8'hFF : 8'(v);
	endfunction

	// one beat of the blur: returns 1 when the beat releases a result
	function automatic bit blur_step(input logic k, input pix_t p, output result_t r,
		output bit swallowed);
		int unsigned w, h, npix, total, n, cn, cnt, sr, sg, sb, i, j;
		pix_t incoming;
		r = '0;
		swallowed = 1'b0;
		w = eff_w();
		h = eff_h();
		npix = w * h;
		total = npix + w + 1;
		if (taken_n >= total) begin
			if (k) begin
				swallowed = 1'b1;
				return 1'b0;
			end
			restart_frame();
		end
		n = taken_n;
		if (n < w)
			cn = n;
		else if (n == w)
			cn = 0;
		else
			cn = (col_at + 1 >= w) ? 0 : col_at + 1;
		incoming = (n < npix && !k) ? p : '0;
		for (i = 0; i < 2; i++)
			for (j = 0; j < 3; j++)
				win_col[i][j] = win_col[i + 1][j];
		win_col[2][0] = upper_line[cn];
		win_col[2][1] = lower_line[cn];
		win_col[2][2] = incoming;
		if (n < npix) begin
			upper_line[cn] = win_col[2][1];
			lower_line[cn] = incoming;
		end
		taken_n = n + 1;
		if (n < w + 1)
			return 1'b0;
		sr = 0;
		sg = 0;
		sb = 0;
		cnt = 0;
		for (i = 0; i < 3; i++) begin
			if ((i == 0 && col_at == 0) || (i == 2 && col_at + 1 >= w))
				continue;
			for (j = 0; j < 3; j++) begin
				if ((j == 0 && row_at == 0) || (j == 2 && row_at + 1 >= h))
					continue;
				sr += win_col[i][j].r;
				sg += win_col[i][j].g;
				sb += win_col[i][j].b;
				cnt++;
			end
		end
		if (cnt == 0)
			cnt = 1;
		r.px.r = round_mean(sr, cnt);
		r.px.g = round_mean(sg, cnt);
		r.px.b = round_mean(sb, cnt);
		r.fe = (row_at + 1 >= h && col_at + 1 >= w);
		if (col_at + 1 >= w) begin
			col_at = 0;
			row_at++;
		end else begin
			col_at++;
		end
		return 1'b1;
	endfunction

	task automatic send_beat(input logic k, input pix_t p, input logic known, input result_t want);
		int unsigned gap;
		result_t got;
		bit made;
		bit swallowed;
		gap = idle_len();
		if (gap != 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.kind  <= k;
		pix_if.red   <= p.r;
		pix_if.green <= p.g;
		pix_if.blue  <= p.b;
		do @(posedge clk); while (!pix_if.ready);
		made = blur_step(k, p, got, swallowed);
		if (!swallowed)
			beats_fed++;
		if (known)
			blurred_q.push_back(want);
		else if (made)
			blurred_q.push_back(got);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] value);
		pix_if.valid <= 1'b0;
		while (blurred_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_WIDTH)
			width_reg = 32'(value[10:0]);
		else
			height_reg = 32'(value[11:0]);
		restart_frame();
	endtask

	task automatic cfg_read(input logic idx, input logic [31:0] want_val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want_val)
			report($sformatf("register %0d read %0d want %0d", idx, prdata, want_val));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input bit big);
		int unsigned r, w_val, h_val, w, h, npix, total, stop, n;
		logic [31:0] wv;
		logic [31:0] hv;
		bit rewrite;
		bit cut;
		logic k;
		calm = ($urandom_range(0, 3) == 0);
		if (big) begin
			w_val = 2047;
			h_val = 0;
			rewrite = 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			w_val = (r < 5) ? 0 : (r < 75) ? $urandom_range(1, 6) : $urandom_range(7, 40);
			r = $urandom_range(0, 99);
			h_val = (r < 5) ? 0 : (r < 85) ? $urandom_range(1, 5) :
				(r < 95) ? $urandom_range(6, 12) : $urandom_range(13, 4095);
			if (r == 99)
				h_val = 4095;
			rewrite = need_rewrite || ($urandom_range(0, 1) == 0);
		end
		if (rewrite) begin
			wv = $urandom;
			wv[10:0] = 11'(w_val);
			hv = $urandom;
			hv[11:0] = 12'(h_val);
			if ($urandom_range(0, 1) == 0) begin
				cfg_write(REG_WIDTH, wv);
				cfg_write(REG_HEIGHT, hv);
			end else begin
				cfg_write(REG_HEIGHT, hv);
				cfg_write(REG_WIDTH, wv);
			end
		end
		w = eff_w();
		h = eff_h();
		npix = w * h;
		total = npix + w + 1;
		stop = total;
		cut = big ? 1'b0 : ($urandom_range(0, 6) == 0);
		if (!big && total > 150) begin
			cut = 1'b1;
			stop = $urandom_range(w + 1, 150);
		end else if (cut) begin
			stop = $urandom_range(1, total - 1);
		end
		for (n = 0; n < stop; n++) begin
			if (n < npix)
				k = ($urandom_range(0, 24) == 0);
			else
				k = ($urandom_range(0, 9) != 0);
			send_beat(k, random_pixel(), 1'b0, '0);
		end
		if (!cut)
			repeat ($urandom_range(0, 2)) send_beat(1'b1, random_pixel(), 1'b0, '0);
		need_rewrite = cut || big;
	endtask

	initial begin
		arst_n        = 1'b0;
		pix_if.valid  = 1'b0;
		pix_if.kind   = 1'b0;
		pix_if.red    = '0;
		pix_if.green  = '0;
		pix_if.blue   = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		restart_frame();
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[s]) begin
			case (plan[s].op)
				STEP_WRITE: cfg_write(plan[s].idx, plan[s].value);
				STEP_READ:  cfg_read(plan[s].idx, plan[s].value);
				default:    send_beat(plan[s].kind, plan[s].px, plan[s].known, plan[s].want);
			endcase
		end

		need_rewrite = 1'b1;
		while (beats_fed < ITEMS) begin
			run_phase(!big_done && beats_fed >= ITEMS / 2);
			if (beats_fed >= ITEMS / 2)
				big_done = 1'b1;
		end

		pix_if.valid <= 1'b0;
		while (blurred_q.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS box_blur_3x3_edge_clipped");
		else
			$display("FAIL box_blur_3x3_edge_clipped");
		$finish;
	end

	initial begin : result_sink
		result_t want;
		int unsigned hold;
		res_if.ready = 1'b0;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				if (blurred_q.size() == 0) begin
					report("result beat with nothing pending");
				end else begin
					want = blurred_q.pop_front();
					if (res_if.out_red !== want.px.r)
						report($sformatf("out_red %0d want %0d", res_if.out_red, want.px.r));
					if (res_if.out_green !== want.px.g)
						report($sformatf("out_green %0d want %0d", res_if.out_green, want.px.g));
					if (res_if.out_blue !== want.px.b)
						report($sformatf("out_blue %0d want %0d", res_if.out_blue, want.px.b));
					if (res_if.frame_end !== want.fe)
						report($sformatf("frame_end %0b want %0b", res_if.frame_end, want.fe));
				end
			end
			if (hold != 0) begin
				hold--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold = idle_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
				(psel && penable))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL box_blur_3x3_edge_clipped");
				$finish;
			end
		end
	end

endmodule
